/* sv/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants of the monochrome framebuffer draw engine:
// screen geometry, command and result payloads, and the memory request format.
// ----------------------------------------------------------------------------
package mfb_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 32;
	localparam int STORE_BYTES   = 512;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	// byte index before the range check: 8-bit x plus page number times width
	localparam int IDX_W  = 14;

	localparam logic [2:0] OP_PIXEL  = 3'd0;
	localparam logic [2:0] OP_HLINE  = 3'd1;
	localparam logic [2:0] OP_VLINE  = 3'd2;
	localparam logic [2:0] OP_RECT   = 3'd3;
	localparam logic [2:0] OP_FILL   = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;
	localparam logic [2:0] OP_READ   = 3'd6;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] x_a;
		logic [7:0] y_a;
		logic [7:0] x_b;
		logic [7:0] y_b;
		logic [7:0] run_length;
		logic       pixel_value;
		logic [8:0] read_address;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] done_opcode;
	} result_t;

	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_READ,
		MOP_SET,
		MOP_CLR,
		MOP_ZERO
	} mem_op_t;

	typedef struct packed {
		mem_op_t           op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        mask;
	} mem_req_t;

endpackage

/* sv/mfb_store.sv */
// ----------------------------------------------------------------------------
// mfb_store
// Framebuffer memory with a two-stage read-modify-write pipe. Accepts one
// request per cycle; back-to-back updates of the same byte are forwarded.
// ----------------------------------------------------------------------------
module mfb_store (
	input  logic             clk,
	input  logic             arst_n,
	input  mfb_pkg::mem_req_t req,
	output logic             pend,
	output logic [7:0]       rd_data
);

	logic [7:0] store_q [mfb_pkg::STORE_BYTES];

	mfb_pkg::mem_op_t          op_s1;
	logic [mfb_pkg::ADDR_W-1:0] addr_s1;
	logic [7:0]                mask_s1;
	logic [7:0]                rdata_s1;

	logic                      fwd_vld_q;
	logic [mfb_pkg::ADDR_W-1:0] fwd_addr_q;
	logic [7:0]                fwd_data_q;

	logic [7:0] base;
	logic [7:0] wdata;
	logic       wr_en;

	// the previous write landed on the same edge this read was taken
	assign base = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata_s1;

	always_comb begin
		wdata = base;
		wr_en = 1'b0;
		unique case (op_s1)
			mfb_pkg::MOP_SET: begin
				wdata = base | mask_s1;
				wr_en = 1'b1;
			end
			mfb_pkg::MOP_CLR: begin
				wdata = base & ~mask_s1;
				wr_en = 1'b1;
			end
			mfb_pkg::MOP_ZERO: begin
				wdata = 8'h00;
				wr_en = 1'b1;
			end
			default: begin
				wdata = base;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.op != mfb_pkg::MOP_NONE) begin
			rdata_s1 <= store_q[req.addr];
		end
		if (wr_en) begin
			store_q[addr_s1] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1     <= mfb_pkg::MOP_NONE;
			fwd_vld_q <= 1'b0;
		end else begin
			op_s1     <= req.op;
			fwd_vld_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= req.addr;
		mask_s1    <= req.mask;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wdata;
	end

	assign pend    = (op_s1 != mfb_pkg::MOP_NONE);
	assign rd_data = base;

endmodule

/* sv/mfb_walker.sv */
// ----------------------------------------------------------------------------
// mfb_walker
// Pixel sequencer for draw commands. Breaks a command into rectangular
// segments and walks them one pixel per cycle, issuing byte updates.
// ----------------------------------------------------------------------------
module mfb_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mfb_pkg::cmd_t     cmd,
	output logic              active,
	output mfb_pkg::mem_req_t req
);

	mfb_pkg::cmd_t cmd_q;
	logic          active_q;
	logic [1:0]    seg_q;
	logic [7:0]    i_q;
	logic [7:0]    j_q;

	logic [7:0] w;
	logic [7:0] h;
	logic [7:0] x0;
	logic [7:0] y0;
	logic [8:0] ncols;
	logic [8:0] nrows;
	logic [1:0] last_seg;
	logic       empty;
	logic       last_i;
	logic       last_j;
	logic [7:0] px;
	logic [7:0] py;
	logic [mfb_pkg::IDX_W-1:0] idx;
	logic       on_screen;

	assign w = cmd_q.x_b - cmd_q.x_a + 8'd1;
	assign h = cmd_q.y_b - cmd_q.y_a;

	always_comb begin
		x0       = cmd_q.x_a;
		y0       = cmd_q.y_a;
		ncols    = 9'd1;
		nrows    = 9'd1;
		last_seg = 2'd0;
		unique case (cmd_q.opcode)
			mfb_pkg::OP_PIXEL: begin
				ncols = 9'd1;
				nrows = 9'd1;
			end
			mfb_pkg::OP_HLINE: begin
				ncols = {1'b0, cmd_q.run_length};
			end
			mfb_pkg::OP_VLINE: begin
				nrows = {1'b0, cmd_q.run_length};
			end
			mfb_pkg::OP_RECT: begin
				last_seg = 2'd3;
				unique case (seg_q)
					2'd0: begin
						ncols = {1'b0, w};
					end
					2'd1: begin
						y0    = cmd_q.y_b;
						ncols = {1'b0, w};
					end
					2'd2: begin
						nrows = {1'b0, h};
					end
					default: begin
						x0    = cmd_q.x_b;
						nrows = {1'b0, h};
					end
				endcase
			end
			mfb_pkg::OP_FILL: begin
				ncols = {1'b0, w};
				nrows = {1'b0, h} + 9'd1;
			end
			default: begin
				ncols = 9'd0;
			end
		endcase
	end

	assign empty  = (ncols == 9'd0) || (nrows == 9'd0);
	assign last_i = ({1'b0, i_q} == (ncols - 9'd1));
	assign last_j = ({1'b0, j_q} == (nrows - 9'd1));
	assign px     = x0 + i_q;
	assign py     = y0 + j_q;

	assign idx = mfb_pkg::IDX_W'(px)
		+ mfb_pkg::IDX_W'(py[7:3]) * mfb_pkg::IDX_W'(mfb_pkg::SCREEN_WIDTH);
	assign on_screen = ({1'b0, px} < 9'(mfb_pkg::SCREEN_WIDTH))
		&& ({1'b0, py} < 9'(mfb_pkg::SCREEN_HEIGHT))
		&& (idx < mfb_pkg::IDX_W'(mfb_pkg::STORE_BYTES));

	always_comb begin
		req.op   = mfb_pkg::MOP_NONE;
		req.addr = idx[mfb_pkg::ADDR_W-1:0];
		req.mask = 8'd1 << py[2:0];
		if (active_q && !empty && on_screen) begin
			if ((cmd_q.opcode == mfb_pkg::OP_PIXEL) && !cmd_q.pixel_value) begin
				req.op = mfb_pkg::MOP_CLR;
			end else begin
				req.op = mfb_pkg::MOP_SET;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
		end
	end

	// columns inner, rows outer, then next segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			seg_q    <= 2'd0;
			i_q      <= 8'd0;
			j_q      <= 8'd0;
		end else if (load) begin
			active_q <= 1'b1;
			seg_q    <= 2'd0;
			i_q      <= 8'd0;
			j_q      <= 8'd0;
		end else if (active_q) begin
			if (empty || (last_i && last_j)) begin
				i_q <= 8'd0;
				j_q <= 8'd0;
				if (seg_q == last_seg) begin
					active_q <= 1'b0;
				end else begin
					seg_q <= seg_q + 2'd1;
				end
			end else if (last_i) begin
				i_q <= 8'd0;
				j_q <= j_q + 8'd1;
			end else begin
				i_q <= i_q + 8'd1;
			end
		end
	end

	assign active = active_q;

endmodule

/* sv/mono_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Page-organized monochrome framebuffer with pixel, line, rectangle, fill,
// clear and byte readout commands.
// ----------------------------------------------------------------------------
// After reset the block sweeps the framebuffer to zero, one byte per cycle,
// and holds busy high through the sweep; the first command can be taken only
// once it is done. A command is taken when start is high and busy
// is low; done pulses for one cycle with the result and cannot be held off by
// the receiver, and the next command may be issued in that same cycle.
// Drawing runs one pixel per cycle through a read-modify-write pipe on the
// single framebuffer memory; every pixel of a draw command is visited, clipped
// pixels included, and each empty line or empty rectangle side also takes its
// own step. Clear sweeps the whole store, and a read past the store or the
// unused opcode issues no memory access.
module mono_framebuffer_draw_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mfb_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done,
	output mfb_pkg::result_t  result
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t                     state_q;
	mfb_pkg::cmd_t              cmd_q;
	mfb_pkg::result_t           result_q;
	logic                       done_q;
	logic [mfb_pkg::ADDR_W-1:0] clr_cnt_q;

	logic              accept;
	logic              walk_load;
	logic              walk_active;
	logic              rd_ok;
	logic              clr_last;
	logic              pend;
	logic [7:0]        rd_data;
	mfb_pkg::mem_req_t walk_req;
	mfb_pkg::mem_req_t req;

	assign accept   = start && (state_q == ST_IDLE);
	assign rd_ok    = mfb_pkg::IDX_W'(cmd.read_address) < mfb_pkg::IDX_W'(mfb_pkg::STORE_BYTES);
	assign clr_last = (clr_cnt_q == mfb_pkg::ADDR_W'(mfb_pkg::STORE_BYTES - 1));

	assign walk_load = accept && (cmd.opcode != mfb_pkg::OP_CLEAR)
		&& (cmd.opcode != mfb_pkg::OP_READ) && (cmd.opcode != mfb_pkg::OP_UNUSED);

	mfb_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (walk_load),
		.cmd    (cmd),
		.active (walk_active),
		.req    (walk_req)
	);

	always_comb begin
		req.op   = mfb_pkg::MOP_NONE;
		req.addr = clr_cnt_q;
		req.mask = 8'h00;
		unique case (state_q)
			ST_WALK: begin
				req = walk_req;
			end
			ST_INIT, ST_SWEEP: begin
				req.op = mfb_pkg::MOP_ZERO;
			end
			ST_IDLE: begin
				if (accept && (cmd.opcode == mfb_pkg::OP_READ) && rd_ok) begin
					req.op   = mfb_pkg::MOP_READ;
					req.addr = mfb_pkg::ADDR_W'(cmd.read_address);
				end
			end
			default: begin
				req.op = mfb_pkg::MOP_NONE;
			end
		endcase
	end

	mfb_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.pend    (pend),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= (state_q == ST_DRAIN) && !pend;
			unique case (state_q)
				ST_INIT: begin
					if (clr_last) begin
						clr_cnt_q <= '0;
						state_q   <= ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + mfb_pkg::ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						result_q.read_data   <= 8'h00;
						result_q.done_opcode <= cmd.opcode;
						clr_cnt_q            <= '0;
						unique case (cmd.opcode) inside
							mfb_pkg::OP_PIXEL, mfb_pkg::OP_HLINE, mfb_pkg::OP_VLINE,
							mfb_pkg::OP_RECT, mfb_pkg::OP_FILL: begin
								state_q <= ST_WALK;
							end
							mfb_pkg::OP_CLEAR: begin
								state_q <= ST_SWEEP;
							end
							default: begin
								state_q <= ST_DRAIN;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (!walk_active) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_SWEEP: begin
					if (clr_last) begin
						clr_cnt_q <= '0;
						state_q   <= ST_DRAIN;
					end else begin
						clr_cnt_q <= clr_cnt_q + mfb_pkg::ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					// hold until the last update has been written back
					if (pend) begin
						if (cmd_q.opcode == mfb_pkg::OP_READ) begin
							result_q.read_data <= rd_data;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* sv/mfb_checker.sv */
// ----------------------------------------------------------------------------
// mfb_checker
// Port-level checks of the draw engine's command and result transactions.
// ----------------------------------------------------------------------------
module mfb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input mfb_pkg::cmd_t    cmd,
	input logic             busy,
	input logic             done,
	input mfb_pkg::result_t result
);

	// a result only appears once the block is free again
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// an accepted transaction makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// no result in the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> !done)
		else $error("result without processing time");

	// the strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held longer than one cycle");

	// only reads return data
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.done_opcode != mfb_pkg::OP_READ)) |-> (result.read_data == 8'h00))
		else $error("nonzero read_data on a non-read result");

endmodule

bind mono_framebuffer_draw_engine mfb_checker u_mfb_checker (.*);
